// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the ring buffer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BRB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ring buffer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define BRB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ring buffer assertion failed");

`endif

// File: hdl/brb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the block ring buffer.
package brb_pkg;

   localparam int DEPTH_DEF     = 1024;
   localparam int MAX_BURST_DEF = 64;

   // Fixed field widths
   localparam int CMD_W      = 3;
   localparam int SAMPLE_W   = 64;
   localparam int COUNT_W    = 11;
   localparam int ADJ_W      = 12;
   localparam int STATUS_W   = 2;
   localparam int LEVEL_W    = 11;
   localparam int FMT_W      = 2;
   localparam int DELAY_W    = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE   = 3'd0,
      CMD_READ    = 3'd1,
      CMD_SKIP_WR = 3'd2,
      CMD_SKIP_RD = 3'd3,
      CMD_RESTART = 3'd4,
      CMD_CLEAR   = 3'd5,
      CMD_QUERY   = 3'd6
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_UNDERRUN = 2'd2,
      ST_REFUSED  = 2'd3
   } status_type;

   typedef enum logic [FMT_W-1:0] {
      FMT_64 = 2'd0,
      FMT_32 = 2'd1,
      FMT_16 = 2'd2,
      FMT_8  = 2'd3
   } fmt_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORMAT = 1'b0,
      CSR_DELAY  = 1'b1
   } csr_index_type;

   // What a transaction turns into once accepted
   typedef enum logic [1:0] {
      OUT_SINGLE = 2'd0,
      OUT_BURST  = 2'd1,
      OUT_WIPE   = 2'd2
   } outcome_type;

   typedef enum logic [2:0] {
      S_INIT  = 3'd0,
      S_IDLE  = 3'd1,
      S_RESP  = 3'd2,
      S_BURST = 3'd3,
      S_WIPE  = 3'd4
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;
      logic sweep;
      logic burst_step;
      logic in_burst;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      outcome_type outcome;
      logic        sweep_done;
      logic        burst_final;
   } dp_stat_type;

endpackage

// File: hdl/brb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the block ring buffer.
module brb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  brb_pkg::dp_stat_type   stat,
   output brb_pkg::ctrl_cmd_type  ctl
);

   brb_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brb_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brb_pkg::S_INIT: begin
            if (stat.sweep_done) state_in = brb_pkg::S_IDLE;
         end
         brb_pkg::S_IDLE: begin
            if (req_valid) begin
               case (stat.outcome)
                  brb_pkg::OUT_BURST: state_in = brb_pkg::S_BURST;
                  brb_pkg::OUT_WIPE:  state_in = brb_pkg::S_WIPE;
                  default:            state_in = brb_pkg::S_RESP;
               endcase
            end
         end
         brb_pkg::S_RESP: begin
            if (rsp_ready) state_in = brb_pkg::S_IDLE;
         end
         brb_pkg::S_BURST: begin
            if (rsp_ready && stat.burst_final) state_in = brb_pkg::S_IDLE;
         end
         brb_pkg::S_WIPE: begin
            // response goes out once the store is clear
            if (stat.sweep_done) state_in = brb_pkg::S_RESP;
         end
         default: state_in = brb_pkg::S_INIT;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      ctl.accept     = 1'b0;
      ctl.sweep      = 1'b0;
      ctl.burst_step = 1'b0;
      ctl.in_burst   = 1'b0;
      case (state_ff)
         brb_pkg::S_INIT: begin
            ctl.sweep = 1'b1;
         end
         brb_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            ctl.accept = req_valid;
         end
         brb_pkg::S_RESP: begin
            rsp_valid = 1'b1;
         end
         brb_pkg::S_BURST: begin
            rsp_valid      = 1'b1;
            ctl.in_burst   = 1'b1;
            ctl.burst_step = rsp_ready;
         end
         brb_pkg::S_WIPE: begin
            ctl.sweep = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/brb_datapath.sv
`timescale 1ns / 1ps
// Datapath of the block ring buffer: sample store, pointers, fill and registers.
module brb_datapath #(
   parameter int DEPTH     = brb_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  brb_pkg::ctrl_cmd_type                 ctl,
   output brb_pkg::dp_stat_type                  stat,
   input  logic [brb_pkg::CMD_W-1:0]             req_cmd,
   input  logic [brb_pkg::SAMPLE_W-1:0]          req_sample,
   input  logic [brb_pkg::COUNT_W-1:0]           req_count,
   input  logic signed [brb_pkg::ADJ_W-1:0]      req_height_adjust,
   input  logic                                  csr_valid,
   input  logic [brb_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [brb_pkg::CSR_DATA_W-1:0]        csr_wdata,
   output logic [brb_pkg::STATUS_W-1:0]          rsp_status,
   output logic [brb_pkg::SAMPLE_W-1:0]          rsp_sample_out,
   output logic                                  rsp_last,
   output logic [brb_pkg::LEVEL_W-1:0]           rsp_fill_level,
   output logic [brb_pkg::LEVEL_W-1:0]           rsp_free_space
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int SUM_W  = PTR_W + 1;
   localparam int BL_W   = $clog2(MAX_BURST + 1);
   localparam int AW     = ((FILL_W > brb_pkg::ADJ_W) ? FILL_W : brb_pkg::ADJ_W) + 2;
   localparam int CW     = brb_pkg::COUNT_W;

   // Add modulo DEPTH for sums known to stay below twice DEPTH
   function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
      logic [SUM_W-1:0] d;
      d = s - SUM_W'(DEPTH);
      return (s >= SUM_W'(DEPTH)) ? PTR_W'(d) : PTR_W'(s);
   endfunction

   brb_pkg::fmt_type         fmt_ff;
   logic [brb_pkg::DELAY_W-1:0] delay_ff;
   logic [PTR_W-1:0]         rp_ff, rp_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic [PTR_W-1:0]         bwp_ff, bwp_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic                     drop_ff, drop_in;
   logic [PTR_W-1:0]         bp_ff, bp_in;
   logic [BL_W-1:0]          blk_ff, blk_in;
   logic [PTR_W-1:0]         clr_ff, clr_in;
   brb_pkg::status_type      status_ff, status_in;
   logic [brb_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic [brb_pkg::SAMPLE_W-1:0] mem [DEPTH];

   brb_pkg::cmd_type         cmd;
   brb_pkg::outcome_type     outcome;
   logic signed [AW-1:0]     count_s, adj_s, fill_s, depth_s, total_s;
   logic                     blk_over, cnt_gt_fill, skip_over, mid_block;
   logic [BL_W-1:0]          burst_n;
   logic [PTR_W-1:0]         wp;
   logic                     wr_en;
   logic [PTR_W-1:0]         wr_addr;
   logic                     mem_we;
   logic [PTR_W-1:0]         mem_addr;
   logic [brb_pkg::SAMPLE_W-1:0] mem_wdata, fmt_mask;
   logic                     sweep_done;

   // Operand preparation
   always_comb begin
      cmd         = brb_pkg::cmd_type'(req_cmd);
      count_s     = AW'($signed({1'b0, req_count}));
      adj_s       = AW'(req_height_adjust);
      fill_s      = AW'($signed({1'b0, fill_ff}));
      depth_s     = AW'(DEPTH);
      total_s     = count_s + adj_s + fill_s;
      blk_over    = total_s > depth_s;
      cnt_gt_fill = count_s > fill_s;
      skip_over   = (count_s + fill_s) > depth_s;
      mid_block   = rem_ff != '0;
      burst_n     = (count_s > AW'(MAX_BURST)) ? BL_W'(MAX_BURST) : BL_W'(req_count);
      wp          = wrap(SUM_W'(rp_ff) + SUM_W'(fill_ff));
      sweep_done  = clr_ff == PTR_W'(DEPTH - 1);
   end

   // Stored sample size
   always_comb begin
      case (fmt_ff)
         brb_pkg::FMT_32: fmt_mask = 64'h0000_0000_FFFF_FFFF;
         brb_pkg::FMT_16: fmt_mask = 64'h0000_0000_0000_FFFF;
         brb_pkg::FMT_8:  fmt_mask = 64'h0000_0000_0000_00FF;
         default:         fmt_mask = '1;
      endcase
   end

   // Kind of work the offered transaction leads to
   always_comb begin
      if (cmd == brb_pkg::CMD_RESTART) begin
         outcome = brb_pkg::OUT_WIPE;
      end else if (mid_block) begin
         outcome = brb_pkg::OUT_SINGLE;
      end else if (cmd == brb_pkg::CMD_CLEAR) begin
         outcome = brb_pkg::OUT_WIPE;
      end else if (cmd == brb_pkg::CMD_READ && !cnt_gt_fill && burst_n != '0) begin
         outcome = brb_pkg::OUT_BURST;
      end else begin
         outcome = brb_pkg::OUT_SINGLE;
      end
   end

   // Transaction execution
   always_comb begin
      rp_in     = rp_ff;
      fill_in   = fill_ff;
      bwp_in    = bwp_ff;
      rem_in    = rem_ff;
      drop_in   = drop_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = bwp_ff;
      if (ctl.accept) begin
         status_in = brb_pkg::ST_OK;
         if (cmd == brb_pkg::CMD_RESTART) begin
            fill_in = ($signed({1'b0, delay_ff}) > depth_s) ? FILL_W'(DEPTH)
                                                            : FILL_W'(delay_ff);
            rem_in  = '0;
            drop_in = 1'b0;
         end else if (mid_block) begin
            if (cmd != brb_pkg::CMD_WRITE) begin
               status_in = brb_pkg::ST_REFUSED;
            end else begin
               if (drop_ff) begin
                  status_in = brb_pkg::ST_OVERFLOW;
               end else begin
                  wr_en  = 1'b1;
                  bwp_in = wrap(SUM_W'(bwp_ff) + SUM_W'(1));
               end
               rem_in = rem_ff - CW'(1);
               if (rem_ff == CW'(1)) drop_in = 1'b0;
            end
         end else begin
            case (cmd)
               brb_pkg::CMD_WRITE: begin
                  if (blk_over) begin
                     status_in = brb_pkg::ST_OVERFLOW;
                     if (req_count != '0) begin
                        rem_in  = req_count - CW'(1);
                        drop_in = req_count != CW'(1);
                     end
                  end else begin
                     fill_in = total_s[AW-1] ? '0 : FILL_W'(total_s);
                     if (req_count != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = wp;
                        bwp_in  = wrap(SUM_W'(wp) + SUM_W'(1));
                        rem_in  = req_count - CW'(1);
                        drop_in = 1'b0;
                     end
                  end
               end
               brb_pkg::CMD_READ: begin
                  if (cnt_gt_fill) begin
                     status_in = brb_pkg::ST_UNDERRUN;
                  end else if (burst_n != '0) begin
                     fill_in = fill_ff - FILL_W'(burst_n);
                     rp_in   = wrap(SUM_W'(rp_ff) + SUM_W'(burst_n));
                  end
               end
               brb_pkg::CMD_SKIP_WR: begin
                  if (skip_over) status_in = brb_pkg::ST_OVERFLOW;
                  else           fill_in   = fill_ff + FILL_W'(req_count);
               end
               brb_pkg::CMD_SKIP_RD: begin
                  if (cnt_gt_fill) begin
                     status_in = brb_pkg::ST_UNDERRUN;
                  end else begin
                     fill_in = fill_ff - FILL_W'(req_count);
                     rp_in   = wrap(SUM_W'(rp_ff) + SUM_W'(req_count));
                  end
               end
               default: begin
                  status_in = brb_pkg::ST_OK;
               end
            endcase
         end
      end
   end

   // Burst pointer and length; the read address is the next pointer value
   always_comb begin
      bp_in  = bp_ff;
      blk_in = blk_ff;
      if (ctl.accept && outcome == brb_pkg::OUT_BURST) begin
         bp_in  = rp_ff;
         blk_in = burst_n;
      end else if (ctl.burst_step) begin
         bp_in  = wrap(SUM_W'(bp_ff) + SUM_W'(1));
         blk_in = blk_ff - BL_W'(1);
      end
   end

   // Clearing sweep counter, returns to zero when done
   always_comb begin
      clr_in = clr_ff;
      if (ctl.sweep) clr_in = sweep_done ? '0 : clr_ff + PTR_W'(1);
   end

   // Memory write port
   always_comb begin
      mem_we    = ctl.sweep || wr_en;
      mem_addr  = ctl.sweep ? clr_ff : wr_addr;
      mem_wdata = ctl.sweep ? '0 : (req_sample & fmt_mask);
   end

   // Sample store
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_data_ff <= mem[bp_in];
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff   <= brb_pkg::FMT_64;
         delay_ff <= '0;
         rp_ff    <= '0;
         fill_ff  <= '0;
         bwp_ff   <= '0;
         rem_ff   <= '0;
         drop_ff  <= 1'b0;
         bp_ff    <= '0;
         blk_ff   <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (brb_pkg::csr_index_type'(csr_index))
               brb_pkg::CSR_FORMAT: fmt_ff   <= brb_pkg::fmt_type'(csr_wdata[brb_pkg::FMT_W-1:0]);
               brb_pkg::CSR_DELAY:  delay_ff <= csr_wdata;
               default:             delay_ff <= delay_ff;
            endcase
         end
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
         bwp_ff  <= bwp_in;
         rem_ff  <= rem_in;
         drop_ff <= drop_in;
         bp_ff   <= bp_in;
         blk_ff  <= blk_in;
         clr_ff  <= clr_in;
      end
   end

   // Response status
   always_ff @(posedge clock) begin
      status_ff <= status_in;
   end

   // Status to controller
   always_comb begin
      stat.outcome     = outcome;
      stat.sweep_done  = sweep_done;
      stat.burst_final = blk_ff == BL_W'(1);
   end

   // Response fields
   always_comb begin
      rsp_status     = status_ff;
      rsp_sample_out = ctl.in_burst ? rd_data_ff : '0;
      rsp_last       = ctl.in_burst ? (blk_ff == BL_W'(1)) : 1'b1;
      rsp_fill_level = brb_pkg::LEVEL_W'(fill_ff);
      rsp_free_space = brb_pkg::LEVEL_W'(FILL_W'(DEPTH) - fill_ff);
   end

endmodule

// File: hdl/block_ring_buffer_with_fill_control_core.sv
`timescale 1ns / 1ps
// Top level of the block ring buffer with fill control.
// The block holds DEPTH samples in one single-port-write, single-port-read memory and
// works on one transaction at a time. After reset it clears the memory one entry per
// cycle with req_ready low; restart, and clear outside a write block, run the same
// sweep before their response. Every other command is accepted in the idle state and
// gets a single response; a read burst of n samples streams n responses at one per
// cycle while rsp_ready is high, from the registered memory read port.
// Configuration writes are taken in any cycle (csr_ready is always high).
module block_ring_buffer_with_fill_control_core #(
   parameter int DEPTH     = brb_pkg::DEPTH_DEF,
   parameter int MAX_BURST = brb_pkg::MAX_BURST_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [brb_pkg::CMD_W-1:0]         req_cmd,
   input  logic [brb_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [brb_pkg::COUNT_W-1:0]       req_count,
   input  logic signed [brb_pkg::ADJ_W-1:0]  req_height_adjust,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [brb_pkg::STATUS_W-1:0]      rsp_status,
   output logic [brb_pkg::SAMPLE_W-1:0]      rsp_sample_out,
   output logic                              rsp_last,
   output logic [brb_pkg::LEVEL_W-1:0]       rsp_fill_level,
   output logic [brb_pkg::LEVEL_W-1:0]       rsp_free_space,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [brb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [brb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   brb_pkg::ctrl_cmd_type ctl;
   brb_pkg::dp_stat_type  stat;

   assign csr_ready = 1'b1;

   // Controller
   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Datapath
   brb_datapath #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .stat              (stat),
      .req_cmd           (req_cmd),
      .req_sample        (req_sample),
      .req_count         (req_count),
      .req_height_adjust (req_height_adjust),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_status        (rsp_status),
      .rsp_sample_out    (rsp_sample_out),
      .rsp_last          (rsp_last),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_free_space    (rsp_free_space)
   );

endmodule

// File: hdl/brb_checker.sv
`timescale 1ns / 1ps
// Port-level assertion checker of the block ring buffer, with its bind.
`include "assert_macros.svh"

module brb_checker #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [brb_pkg::STATUS_W-1:0]  rsp_status,
   input logic [brb_pkg::SAMPLE_W-1:0]  rsp_sample_out,
   input logic                          rsp_last,
   input logic [brb_pkg::LEVEL_W-1:0]   rsp_fill_level,
   input logic [brb_pkg::LEVEL_W-1:0]   rsp_free_space
);

   // one transaction at a time: no new request while a response is pending
   `BRB_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)

   // fill and free space always add up to the depth
   `BRB_ASSERT_IMP(a_level_sum, clock, reset, rsp_valid, brb_pkg::LEVEL_W'(rsp_fill_level + rsp_free_space) == brb_pkg::LEVEL_W'(DEPTH))

   // only burst data carries more than one response, all ok
   `BRB_ASSERT_IMP(a_burst_ok, clock, reset, rsp_valid && !rsp_last, rsp_status == brb_pkg::ST_OK)

   // burst streams without gaps
   `BRB_ASSERT_NXT(a_burst_stream, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

   // stalled response holds
   `BRB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample_out) && $stable(rsp_status))

endmodule

bind block_ring_buffer_with_fill_control_core brb_checker #(.DEPTH(DEPTH)) u_brb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_sample_out (rsp_sample_out),
   .rsp_last       (rsp_last),
   .rsp_fill_level (rsp_fill_level),
   .rsp_free_space (rsp_free_space)
);
